@@ rtl/kts_pkg.sv @@
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants of the keyframe timeline sampler.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int unsigned ENTRY_COUNT_DEF = 64;
  localparam int unsigned TICK_BITS_DEF   = 32;

  localparam int unsigned DUR_W      = 16;
  localparam int unsigned POSE_W     = 8;
  localparam int unsigned OFS_W      = 16;
  localparam int unsigned LANES      = 6;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned FRAC_QBITS = 16;
  localparam int unsigned FRAC_ONE   = 65536;
  localparam int unsigned IN_IDX_W   = 6;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned TICK_IN_W  = 32;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_START  = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_e;

  typedef enum logic {
    CFG_FIRST_ENTRY = 1'b0,
    CFG_LAST_ENTRY  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [5:0]          entry_index;
    logic [15:0]         entry_duration;
    logic [7:0]          entry_pose;
    logic signed [15:0]  entry_sway_x;
    logic signed [15:0]  entry_sway_y;
    logic signed [15:0]  entry_sway_z;
    logic signed [15:0]  entry_move_x;
    logic signed [15:0]  entry_move_y;
    logic signed [15:0]  entry_move_z;
    logic [31:0]         now_tick;
  } in_t;

  typedef struct packed {
    logic [7:0]          pose_from;
    logic [7:0]          pose_to;
    logic [16:0]         blend_factor;
    logic signed [15:0]  sway_x;
    logic signed [15:0]  sway_y;
    logic signed [15:0]  sway_z;
    logic signed [15:0]  move_x;
    logic signed [15:0]  move_y;
    logic signed [15:0]  move_z;
    logic [5:0]          current_index;
  } out_t;

  // Offsets: lanes 0..2 are sway x/y/z, lanes 3..5 are move x/y/z.
  typedef struct packed {
    logic [DUR_W-1:0]             dur;
    logic [POSE_W-1:0]            pose;
    logic [LANES-1:0][OFS_W-1:0]  ofs;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_CHECK,
    ST_ADVANCE,
    ST_PER_INIT,
    ST_PER_NEXT,
    ST_PER_ADD,
    ST_SKIP_INIT,
    ST_SKIP_DIV,
    ST_SKIP_APPLY,
    ST_READ_FROM,
    ST_READ_TO,
    ST_LATCH_TO,
    ST_FRAC_DIV,
    ST_FRAC_DONE,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WRITE,
    OP_START,
    OP_LOAD,
    OP_SET_END,
    OP_STEP,
    OP_PER_INIT,
    OP_PER_NEXT,
    OP_PER_ADD,
    OP_SKIP_INIT,
    OP_DIV_STEP,
    OP_SKIP_APPLY,
    OP_READ_FROM,
    OP_READ_TO,
    OP_LATCH_TO,
    OP_FRAC_DONE,
    OP_MUL,
    OP_ACC,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e      op;
    logic [2:0]  lane;
  } dp_cmd_t;

  typedef struct packed {
    logic behind;
    logic loop_closed;
    logic frac_full;
  } dp_status_t;

endpackage

@@ rtl/keyframe_timeline_sampler.sv @@
// ----------------------------------------------------------------------------
// keyframe_timeline_sampler
// Samples a looping keyframe timeline and blends the two keyframes linearly.
// ----------------------------------------------------------------------------
// Usage: three channels. The configuration channel sets the first and last
// entry of the loop and is always ready. The input channel takes write,
// start and sample requests; write and start give no result. A sample
// returns one beat on the output channel. A sample steps through the
// entries that end before its tick, skips whole loops with the divider when
// the lag spans them, and runs the fraction divider when the factor is
// below one. No new request is taken while a sample is in work; the block
// is ready again in the cycle after the beat is loaded. The entry table
// has a single read port and each step costs one read.
// Reset clears the loop range, the current entry and its start tick; the
// entry table is not cleared and must be written before it is sampled.
// The output beat sits in a register; the next request is taken while it
// waits, but a further sample holds at its last cycle until the beat is taken.
// ----------------------------------------------------------------------------
module keyframe_timeline_sampler #(
  parameter int unsigned ENTRY_COUNT = kts_pkg::ENTRY_COUNT_DEF,
  parameter int unsigned TICK_BITS   = kts_pkg::TICK_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  kts_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output kts_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [kts_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import kts_pkg::*;

  logic [CFG_DATA_W-1:0] first_q, last_q;
  dp_cmd_t               cmd;
  dp_status_t            status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FIRST_ENTRY: first_q <= cfg_data_i;
        CFG_LAST_ENTRY:  last_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  kts_ctrl #(
    .ENTRY_COUNT(ENTRY_COUNT),
    .TICK_BITS  (TICK_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (in_data_i.req_type),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kts_datapath #(
    .ENTRY_COUNT(ENTRY_COUNT),
    .TICK_BITS  (TICK_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .cfg_first_i(first_q),
    .cfg_last_i (last_q),
    .out_data_o (out_data_o)
  );

endmodule

@@ rtl/kts_ram.sv @@
// ----------------------------------------------------------------------------
// kts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/kts_datapath.sv @@
// ----------------------------------------------------------------------------
// kts_datapath
// Entry table, timeline registers, shared restoring divider and the
// multiplier that blends the offsets, all driven by controller commands.
// ----------------------------------------------------------------------------
module kts_datapath #(
  parameter int unsigned ENTRY_COUNT = 64,
  parameter int unsigned TICK_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kts_pkg::dp_cmd_t    cmd_i,
  output kts_pkg::dp_status_t status_o,
  input  kts_pkg::in_t        in_data_i,
  input  logic [5:0]          cfg_first_i,
  input  logic [5:0]          cfg_last_i,
  output kts_pkg::out_t       out_data_o
);
  import kts_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRY_COUNT);
  localparam int unsigned PER_W = $clog2((ENTRY_COUNT + 1) * 65536);
  localparam int unsigned REM_W = PER_W + 1;

  logic [IDX_W-1:0] mod_tab [64];

  for (genvar g = 0; g < 64; g++) begin : g_mod
    assign mod_tab[g] = IDX_W'(g % ENTRY_COUNT);
  end

  logic [IDX_W-1:0] first_mod;
  assign first_mod = mod_tab[cfg_first_i];

  function automatic logic [IDX_W-1:0] next_of(input logic [IDX_W-1:0] i);
    logic wrap;
    wrap = (32'(i) >= 32'(cfg_last_i)) || (32'(i) >= ENTRY_COUNT - 1);
    return wrap ? first_mod : i + IDX_W'(1);
  endfunction

  logic [IDX_W-1:0]            active_q, idx_q, j_q;
  logic [TICK_BITS-1:0]        seg_q, start_q, end_q, now_q, lag_m1_q;
  logic [PER_W-1:0]            period_q;
  logic [REM_W-1:0]            rem_q;
  logic [TICK_BITS-1:0]        num_q;
  logic [FRAC_QBITS-1:0]       quo_q;
  logic                        div_frac_q;
  entry_t                      from_q, to_q;
  logic [FRAC_W-1:0]           f_q;
  logic signed [34:0]          prod_q;
  logic [LANES-1:0][OFS_W-1:0] res_q;
  out_t                        out_q;

  // Entry table.
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic [DUR_W-1:0] dur_rd;

  assign ram_we    = (cmd_i.op == OP_WRITE);
  assign ram_waddr = mod_tab[in_data_i.entry_index];
  assign ram_wdata = '{dur:  in_data_i.entry_duration,
                       pose: in_data_i.entry_pose,
                       ofs:  {in_data_i.entry_move_z, in_data_i.entry_move_y,
                              in_data_i.entry_move_x, in_data_i.entry_sway_z,
                              in_data_i.entry_sway_y, in_data_i.entry_sway_x}};

  always_comb begin
    ram_re    = 1'b1;
    ram_raddr = idx_q;
    unique case (cmd_i.op)
      OP_LOAD:                ram_raddr = active_q;
      OP_STEP, OP_READ_TO:    ram_raddr = next_of(idx_q);
      OP_PER_NEXT:            ram_raddr = next_of(j_q);
      OP_READ_FROM:           ram_raddr = idx_q;
      default:                ram_re    = 1'b0;
    endcase
  end

  kts_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRY_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A zero duration counts as one tick.
  assign dur_rd = (ram_rdata.dur == '0) ? DUR_W'(1) : ram_rdata.dur;

  // Status.
  logic [TICK_BITS-1:0] behind_d, r_val;
  assign behind_d = now_q - end_q;
  assign r_val    = end_q - now_q;

  assign status_o.behind      = (behind_d != '0) && !behind_d[TICK_BITS-1];
  assign status_o.loop_closed = (j_q == idx_q);
  assign status_o.frac_full   = (r_val >= TICK_BITS'(from_q.dur));

  // Divider step, one quotient bit per cycle.
  logic [REM_W-1:0] divisor, shifted, rem_step;
  logic             div_ge;
  assign divisor  = div_frac_q ? REM_W'(from_q.dur) : REM_W'(period_q);
  assign shifted  = {rem_q[REM_W-2:0], num_q[TICK_BITS-1]};
  assign div_ge   = (shifted >= divisor);
  assign rem_step = div_ge ? shifted - divisor : shifted;

  logic [TICK_BITS-1:0] skip;
  assign skip = lag_m1_q - TICK_BITS'(rem_q);

  // Blend arithmetic: (from - to) * f, then round to nearest and add to.
  logic signed [16:0] diff;
  logic signed [17:0] f_s;
  logic signed [34:0] rounded;
  logic [OFS_W-1:0]   acc;
  assign diff    = {from_q.ofs[cmd_i.lane][OFS_W-1], from_q.ofs[cmd_i.lane]}
                 - {to_q.ofs[cmd_i.lane][OFS_W-1], to_q.ofs[cmd_i.lane]};
  assign f_s     = {1'b0, f_q};
  assign rounded = prod_q + 35'sd32768;
  assign acc     = to_q.ofs[cmd_i.lane] + rounded[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      seg_q    <= '0;
    end else begin
      if (cmd_i.op == OP_START) begin
        active_q <= mod_tab[in_data_i.entry_index];
        seg_q    <= TICK_BITS'(in_data_i.now_tick);
      end else if (cmd_i.op == OP_READ_FROM) begin
        active_q <= idx_q;
        seg_q    <= start_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        now_q   <= TICK_BITS'(in_data_i.now_tick);
        idx_q   <= active_q;
        start_q <= seg_q;
      end
      OP_SET_END: begin
        end_q <= start_q + TICK_BITS'(dur_rd);
      end
      OP_STEP: begin
        idx_q   <= next_of(idx_q);
        start_q <= end_q;
      end
      OP_PER_INIT: begin
        j_q      <= idx_q;
        period_q <= '0;
      end
      OP_PER_NEXT: begin
        j_q <= next_of(j_q);
      end
      OP_PER_ADD: begin
        period_q <= period_q + PER_W'(dur_rd);
      end
      OP_SKIP_INIT: begin
        lag_m1_q   <= now_q - end_q - TICK_BITS'(1);
        num_q      <= now_q - end_q - TICK_BITS'(1);
        rem_q      <= '0;
        div_frac_q <= 1'b0;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_step;
        num_q <= num_q << 1;
        quo_q <= {quo_q[FRAC_QBITS-2:0], div_ge};
      end
      OP_SKIP_APPLY: begin
        start_q <= start_q + skip;
        end_q   <= end_q + skip;
      end
      OP_READ_TO: begin
        from_q <= '{dur: dur_rd, pose: ram_rdata.pose, ofs: ram_rdata.ofs};
      end
      OP_LATCH_TO: begin
        to_q       <= ram_rdata;
        f_q        <= FRAC_W'(FRAC_ONE);
        rem_q      <= REM_W'(r_val);
        num_q      <= '0;
        div_frac_q <= 1'b1;
      end
      OP_FRAC_DONE: begin
        f_q <= {1'b0, quo_q};
      end
      OP_MUL: begin
        prod_q <= diff * f_s;
      end
      OP_ACC: begin
        res_q[cmd_i.lane] <= acc;
      end
      OP_OUT: begin
        out_q.pose_from     <= from_q.pose;
        out_q.pose_to       <= to_q.pose;
        out_q.blend_factor  <= f_q;
        out_q.sway_x        <= res_q[0];
        out_q.sway_y        <= res_q[1];
        out_q.sway_z        <= res_q[2];
        out_q.move_x        <= res_q[3];
        out_q.move_y        <= res_q[4];
        out_q.move_z        <= res_q[5];
        out_q.current_index <= 6'(idx_q);
      end
      default: begin
      end
    endcase
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/kts_ctrl.sv @@
// ----------------------------------------------------------------------------
// kts_ctrl
// Sequencer of the sampler: walks the timeline, the loop skip, the divider
// and the blend lanes, and owns the handshakes.
// ----------------------------------------------------------------------------
module kts_ctrl #(
  parameter int unsigned ENTRY_COUNT = 64,
  parameter int unsigned TICK_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          req_type_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  kts_pkg::dp_status_t status_i,
  output kts_pkg::dp_cmd_t    cmd_o
);
  import kts_pkg::*;

  localparam int unsigned CNT_MAX = (ENTRY_COUNT + 1 > TICK_BITS) ? ENTRY_COUNT + 1 : TICK_BITS;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pass_q, pass_d;
  logic             out_valid_q, out_valid_d;
  logic             can_step, out_free;

  assign can_step = status_i.behind && (32'(cnt_q) <= ENTRY_COUNT);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (req_type_i == REQ_SAMPLE)) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cnt_d   = '0;
        pass_d  = 1'b0;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (can_step) begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = ST_ADVANCE;
        end else if (!pass_q && status_i.behind) begin
          state_d = ST_PER_INIT;
        end else begin
          state_d = ST_READ_FROM;
        end
      end
      ST_ADVANCE:  state_d = ST_CHECK;
      ST_PER_INIT: begin
        cnt_d   = '0;
        state_d = ST_PER_NEXT;
      end
      ST_PER_NEXT: state_d = ST_PER_ADD;
      ST_PER_ADD: begin
        if (status_i.loop_closed || (32'(cnt_q) == ENTRY_COUNT)) begin
          state_d = ST_SKIP_INIT;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = ST_PER_NEXT;
        end
      end
      ST_SKIP_INIT: begin
        cnt_d   = '0;
        state_d = ST_SKIP_DIV;
      end
      ST_SKIP_DIV: begin
        if (32'(cnt_q) == TICK_BITS - 1) begin
          state_d = ST_SKIP_APPLY;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SKIP_APPLY: begin
        pass_d  = 1'b1;
        cnt_d   = '0;
        state_d = ST_CHECK;
      end
      ST_READ_FROM: state_d = ST_READ_TO;
      ST_READ_TO:   state_d = ST_LATCH_TO;
      ST_LATCH_TO: begin
        cnt_d   = '0;
        state_d = status_i.frac_full ? ST_MUL : ST_FRAC_DIV;
      end
      ST_FRAC_DIV: begin
        if (32'(cnt_q) == FRAC_QBITS - 1) begin
          cnt_d   = '0;
          state_d = ST_FRAC_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_FRAC_DONE: state_d = ST_MUL;
      ST_MUL:       state_d = ST_ACC;
      ST_ACC: begin
        if (32'(cnt_q) == LANES - 1) begin
          state_d = ST_OUT;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.lane = cnt_q[2:0];
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (req_type_i)
            REQ_WRITE:  cmd_o.op = OP_WRITE;
            REQ_START:  cmd_o.op = OP_START;
            REQ_SAMPLE: cmd_o.op = OP_LOAD;
            default:    cmd_o.op = OP_NONE;
          endcase
        end
      end
      ST_INIT, ST_ADVANCE: cmd_o.op = OP_SET_END;
      ST_CHECK:      cmd_o.op = can_step ? OP_STEP : OP_NONE;
      ST_PER_INIT:   cmd_o.op = OP_PER_INIT;
      ST_PER_NEXT:   cmd_o.op = OP_PER_NEXT;
      ST_PER_ADD:    cmd_o.op = OP_PER_ADD;
      ST_SKIP_INIT:  cmd_o.op = OP_SKIP_INIT;
      ST_SKIP_DIV, ST_FRAC_DIV: cmd_o.op = OP_DIV_STEP;
      ST_SKIP_APPLY: cmd_o.op = OP_SKIP_APPLY;
      ST_READ_FROM:  cmd_o.op = OP_READ_FROM;
      ST_READ_TO:    cmd_o.op = OP_READ_TO;
      ST_LATCH_TO:   cmd_o.op = OP_LATCH_TO;
      ST_FRAC_DONE:  cmd_o.op = OP_FRAC_DONE;
      ST_MUL:        cmd_o.op = OP_MUL;
      ST_ACC:        cmd_o.op = OP_ACC;
      ST_OUT:        cmd_o.op = out_free ? OP_OUT : OP_NONE;
      default:       cmd_o.op = OP_NONE;
    endcase
    if (cmd_o.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/kts_checker.sv @@
// ----------------------------------------------------------------------------
// kts_checker
// Port level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module kts_checker #(
  parameter int unsigned ENTRY_COUNT = kts_pkg::ENTRY_COUNT_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input kts_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input kts_pkg::out_t out_data_o
);
  import kts_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.req_type == REQ_SAMPLE) |=> !in_ready_o)
    else $error("sample did not occupy the block");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while the block was idle");

  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.blend_factor) <= FRAC_ONE))
    else $error("blend factor above one");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.current_index) < ENTRY_COUNT))
    else $error("current entry out of range");

endmodule

bind keyframe_timeline_sampler kts_checker #(
  .ENTRY_COUNT(ENTRY_COUNT)
) u_kts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
